FILE: rtl/ttf_pkg.sv
// Shared types and constants for the thermocouple trimmed filter.
package ttf_pkg;

  localparam int ADC_W  = 12;
  localparam int NTC_W  = 10;
  localparam int HEAT_W = 15;
  localparam int NQ_W   = 9;
  localparam int TQ_W   = 14;

  localparam logic [ADC_W-1:0] NTC_HI_LIMIT = 12'd3325;
  localparam logic [ADC_W-1:0] NTC_LO_LIMIT = 12'd1508;
  localparam logic [8:0]       NTC_NUM      = 9'd500;
  localparam logic [10:0]      NTC_DEN      = 11'd1817;
  localparam logic [6:0]       TC_NUM       = 7'd100;
  localparam logic [5:0]       TC_DEN       = 6'd41;

  // rounded-up reciprocals: ceil(2^22 * 500 / 1817) and ceil(2^18 * 100 / 41)
  localparam int               NTC_SHIFT = 22;
  localparam logic [20:0]      NTC_RECIP = 21'd1154184;
  localparam int               TC_SHIFT  = 18;
  localparam logic [19:0]      TC_RECIP  = 20'd639376;

  localparam logic signed [NTC_W-1:0] CJ_TEMP_MAX = 10'sd400;
  localparam logic signed [NTC_W-1:0] CJ_TEMP_MIN = -10'sd100;

  // one converted word handed from the front end to the filter
  typedef struct packed {
    logic signed [HEAT_W-1:0] raw_heat;
    logic signed [NTC_W-1:0]  cj_temp;
  } conv_t;

endpackage

FILE: rtl/thermocouple_temp_trimmed_filter_unit.sv
// Front end converts a word by reciprocal multiplication; a two-word queue follows.
// While the ring fills, each word is stored and passed on unfiltered; once full, the back end walks
// the ring with one read per cycle, then trims and scales by the reciprocal. The back end takes
// no new word until its last result is accepted.
// Reset clears the queue, ring pointer and fill count; ring contents are not cleared.
module thermocouple_temp_trimmed_filter_unit #(
  parameter int WINDOW = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [11:0] ntc_adc, [23:12] tc_adc
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [9:0] cj_temp, [24:10] htr_temp, rest zero
);
  import ttf_pkg::*;

  logic  fe_valid, fe_ready, q_valid, q_ready;
  conv_t fe_data, q_data;
  logic signed [NTC_W-1:0]  cj_temp;
  logic signed [HEAT_W-1:0] htr_temp;

  ttf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .ntc_adc_i   (s_axis_tdata[11:0]),
    .tc_adc_i    (s_axis_tdata[23:12]),
    .out_valid_o (fe_valid),
    .out_ready_i (fe_ready),
    .out_data_o  (fe_data)
  );

  ttf_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fe_valid),
    .wr_ready_o (fe_ready),
    .wr_data_i  (fe_data),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_data)
  );

  ttf_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_data_i   (q_data),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cj_temp_o   (cj_temp),
    .htr_temp_o  (htr_temp)
  );

  assign m_axis_tdata = {7'b0, htr_temp, cj_temp};

endmodule

FILE: rtl/ttf_front.sv
// Front end: takes ADC words, converts them to temperatures by reciprocal multiplication.
module ttf_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [ttf_pkg::ADC_W-1:0]   ntc_adc_i,
  input  logic [ttf_pkg::ADC_W-1:0]   tc_adc_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ttf_pkg::conv_t              out_data_o
);
  import ttf_pkg::*;

  typedef enum logic [2:0] {
    FE_IDLE = 3'b001,
    FE_CONV = 3'b010,
    FE_DONE = 3'b100
  } fe_state_e;

  fe_state_e               state_q, state_d;
  logic [ADC_W-1:0]        ntc_adc_q, tc_adc_q;
  logic                    clamp_hi_q, clamp_lo_q;
  logic [NQ_W-1:0]         nq_q;
  logic                    nrem_q;
  logic [TQ_W-1:0]         tq_q;

  logic [10:0]             ntc_off;
  logic [31:0]             nprod, tprod;
  logic                    round_up;
  logic signed [10:0]      conv;
  logic signed [NTC_W-1:0] cj_temp;

  assign in_ready_o  = (state_q == FE_IDLE);
  assign out_valid_o = (state_q == FE_DONE);

  // offset into the linear segment; zero when clamped
  assign ntc_off = (clamp_hi_q || clamp_lo_q) ? '0 : 11'(ntc_adc_q - NTC_LO_LIMIT);

  // floor quotients by multiply and shift, exact over the whole input range
  assign nprod = {21'b0, ntc_off} * {11'b0, NTC_RECIP};
  assign tprod = {20'b0, tc_adc_q} * {12'b0, TC_RECIP};

  always_comb begin
    state_d = state_q;
    case (state_q)
      FE_IDLE: begin
        if (in_valid_i) state_d = FE_CONV;
      end
      FE_CONV: begin
        state_d = FE_DONE;
      end
      FE_DONE: begin
        if (out_ready_i) state_d = FE_IDLE;
      end
      default: state_d = FE_IDLE;
    endcase
  end

  // truncation toward zero: round the quotient up while the result stays positive
  assign round_up = (nq_q < 9'd400) && nrem_q;
  assign conv     = 11'sd400 - $signed({2'b00, nq_q}) - $signed({10'b0, round_up});

  always_comb begin
    if (clamp_hi_q)      cj_temp = CJ_TEMP_MIN;
    else if (clamp_lo_q) cj_temp = CJ_TEMP_MAX;
    else                 cj_temp = conv[NTC_W-1:0];
  end

  assign out_data_o.cj_temp  = cj_temp;
  assign out_data_o.raw_heat = HEAT_W'(cj_temp) + $signed({1'b0, tq_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FE_IDLE && in_valid_i) begin
      ntc_adc_q  <= ntc_adc_i;
      tc_adc_q   <= tc_adc_i;
      clamp_hi_q <= ntc_adc_i > NTC_HI_LIMIT;
      clamp_lo_q <= ntc_adc_i < NTC_LO_LIMIT;
    end
    if (state_q == FE_CONV) begin
      nq_q   <= NQ_W'(nprod >> NTC_SHIFT);
      // 500 and 1817 are coprime: the remainder is zero only at either end of the segment
      nrem_q <= (ntc_off != '0) && (ntc_off != NTC_DEN);
      tq_q   <= TQ_W'(tprod >> TC_SHIFT);
    end
  end

endmodule

FILE: rtl/ttf_fifo.sv
// Two-word queue between the converter and the filter.
module ttf_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_valid_i,
  output logic           wr_ready_o,
  input  ttf_pkg::conv_t wr_data_i,
  output logic           rd_valid_o,
  input  logic           rd_ready_i,
  output ttf_pkg::conv_t rd_data_o
);
  import ttf_pkg::*;

  conv_t       mem_q [2];
  logic        wptr_q, rptr_q;
  logic [1:0]  count_q;
  logic        push, pop;

  assign wr_ready_o = (count_q != 2'd2);
  assign rd_valid_o = (count_q != 2'd0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= wr_data_i;
  end

endmodule

FILE: rtl/ttf_back.sv
// Back end: sample ring, min/max/sum walk and trimmed mean; unfiltered until full.
module ttf_back #(
  parameter int WINDOW = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  ttf_pkg::conv_t                   in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [ttf_pkg::NTC_W-1:0]  cj_temp_o,
  output logic signed [ttf_pkg::HEAT_W-1:0] htr_temp_o
);
  import ttf_pkg::*;

  typedef enum logic [4:0] {
    BE_IDLE = 5'b00001,
    BE_WALK = 5'b00010,
    BE_TRIM = 5'b00100,
    BE_DIV  = 5'b01000,
    BE_OUT  = 5'b10000
  } be_state_e;

  localparam int PTR_W = $clog2(WINDOW);
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = HEAT_W + PTR_W + 1;
  // shift wide enough that magnitude times divisor stays below 2^RS: quotient is exact
  localparam int RS    = SUM_W + PTR_W;
  localparam int RM_W  = RS + 1;
  localparam int PR_W  = SUM_W + RM_W;
  localparam logic [RM_W-1:0] RECIP_ONE = RM_W'(((2 ** RS) + WINDOW - 2) / (WINDOW - 1));
  localparam logic [RM_W-1:0] RECIP_TWO = RM_W'(((2 ** RS) + WINDOW - 3) / (WINDOW - 2));

  be_state_e                state_q, state_d;
  logic signed [HEAT_W-1:0] ring [WINDOW];
  logic signed [HEAT_W-1:0] rd_data_q;
  logic [PTR_W-1:0]         wptr_q;
  logic [CNT_W-1:0]         fill_q;
  logic [CNT_W-1:0]         rd_cnt_q;
  logic                     rd_vld_q, first_q;
  logic signed [HEAT_W-1:0] min_q, max_q;
  logic signed [SUM_W-1:0]  sum_q;
  logic [SUM_W-1:0]         mag_q;
  logic                     neg_q, flat_q;
  logic signed [NTC_W-1:0]  ntc_q;
  logic signed [HEAT_W-1:0] heat_q;

  logic                     pop, rd_en, full, all_equal;
  logic signed [SUM_W-1:0]  trimmed;
  logic [RM_W-1:0]          recip;
  logic [PR_W-1:0]          prod;
  logic [HEAT_W-1:0]        quot;

  assign full        = (fill_q == CNT_W'(WINDOW));
  assign in_ready_o  = (state_q == BE_IDLE);
  assign pop         = in_valid_i && (state_q == BE_IDLE);
  assign rd_en       = (state_q == BE_WALK) && (rd_cnt_q < CNT_W'(WINDOW));
  assign out_valid_o = (state_q == BE_OUT);
  assign cj_temp_o   = ntc_q;
  assign htr_temp_o  = heat_q;

  // equal extremes mean every entry is the same: drop just one of them
  assign all_equal = (min_q == max_q);
  assign trimmed   = sum_q - SUM_W'(min_q) - (all_equal ? SUM_W'(0) : SUM_W'(max_q));

  // divide the magnitude by WINDOW-1 or WINDOW-2 through the rounded-up reciprocal
  assign recip = flat_q ? RECIP_ONE : RECIP_TWO;
  assign prod  = PR_W'(mag_q) * PR_W'(recip);
  assign quot  = HEAT_W'(prod >> RS);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BE_IDLE: if (in_valid_i) state_d = full ? BE_WALK : BE_OUT;
      BE_WALK: if (rd_cnt_q == CNT_W'(WINDOW) && !rd_vld_q) state_d = BE_TRIM;
      BE_TRIM: state_d = BE_DIV;
      BE_DIV:  state_d = BE_OUT;
      BE_OUT:  if (out_ready_i) state_d = BE_IDLE;
      default: state_d = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BE_IDLE;
      wptr_q   <= '0;
      fill_q   <= '0;
      rd_cnt_q <= '0;
      rd_vld_q <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (pop) begin
        wptr_q   <= (wptr_q == PTR_W'(WINDOW - 1)) ? '0 : wptr_q + 1'b1;
        if (!full) fill_q <= fill_q + 1'b1;
        rd_cnt_q <= '0;
        first_q  <= 1'b1;
      end
      if (rd_en) rd_cnt_q <= rd_cnt_q + 1'b1;
      if (rd_vld_q) first_q <= 1'b0;
    end
  end

  // sample ring
  always_ff @(posedge clk_i) begin
    if (pop) ring[wptr_q] <= in_data_i.raw_heat;
    if (rd_en) rd_data_q <= ring[rd_cnt_q[PTR_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ntc_q  <= in_data_i.cj_temp;
      heat_q <= in_data_i.raw_heat;
    end
    if (rd_vld_q) begin
      if (first_q) begin
        min_q <= rd_data_q;
        max_q <= rd_data_q;
        sum_q <= SUM_W'(rd_data_q);
      end else begin
        if (rd_data_q < min_q) min_q <= rd_data_q;
        if (rd_data_q > max_q) max_q <= rd_data_q;
        sum_q <= sum_q + SUM_W'(rd_data_q);
      end
    end
    if (state_q == BE_TRIM) begin
      neg_q  <= trimmed[SUM_W-1];
      mag_q  <= trimmed[SUM_W-1] ? $unsigned(-trimmed) : $unsigned(trimmed);
      flat_q <= all_equal;
    end else if (state_q == BE_DIV) begin
      // magnitude quotient with the sign put back: truncates toward zero
      heat_q <= neg_q ? -$signed(quot) : $signed(quot);
    end
  end

endmodule
